// ===== hw/rtl/bld_pkg.sv =====
// ----------------------------------------------------------------------------
// bld_pkg
// Shared types and codes for the bounded list deque: request and response
// beats, operation codes and status codes.
// ----------------------------------------------------------------------------
package bld_pkg;

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DELETE     = 3'd4;
    localparam logic [2:0] OP_CONTAINS   = 3'd5;
    localparam logic [2:0] OP_HEAD       = 3'd6;
    localparam logic [2:0] OP_TAIL       = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // request beat
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
    } bld_req_t;

    // response beat
    typedef struct packed {
        logic [31:0] result_value;
        logic        found;
        logic [4:0]  entry_count;
        logic [1:0]  status;
    } bld_resp_t;

endpackage

// ===== hw/rtl/bld_store.sv =====
// ----------------------------------------------------------------------------
// bld_store
// Entry memory of the list: one write port and one read port, read data
// registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module bld_store #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [VALUE_WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [VALUE_WIDTH-1:0]         rdata
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bld_ctrl.sv =====
// ----------------------------------------------------------------------------
// bld_ctrl
// Sequencer of the list: holds the entry count and walks the entry memory
// one position a cycle to shift entries up or down and to search for a key
// with a single shared compare.
// ----------------------------------------------------------------------------
module bld_ctrl #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  bld_pkg::bld_req_t            req,
    output logic                         busy,
    output logic                         mem_we,
    output logic [$clog2(DEPTH)-1:0]     mem_waddr,
    output logic [VALUE_WIDTH-1:0]       mem_wdata,
    output logic [$clog2(DEPTH)-1:0]     mem_raddr,
    input  logic [VALUE_WIDTH-1:0]       mem_rdata,
    output logic                         fin,
    output bld_pkg::bld_resp_t           fin_resp
);
    import bld_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SHUP = 3'd2;
    localparam logic [2:0] S_SHDN = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_RDWT = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   rd_done_reg, rd_done_next;
    logic                   pend_reg, pend_next;
    logic                   pend_first_reg, pend_first_next;
    logic [2:0]             op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic [VALUE_WIDTH-1:0] res_reg, res_next;

    logic [CW-1:0]          cnt_m1;
    logic [AW-1:0]          last_idx;
    logic                   is_full;
    logic                   is_empty;
    logic                   key_hit;

    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign key_hit  = (mem_rdata == key_reg);
    assign busy     = (state_reg != S_IDLE);

    // next state and memory access
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_done_next    = rd_done_reg;
        pend_next       = pend_reg;
        pend_first_next = pend_first_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pend_addr_next  = pend_addr_reg;
        res_next        = res_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = key_reg;
        mem_raddr       = '0;
        fin             = 1'b0;
        fin_resp        = '0;
        fin_resp.status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = req.op;
                    key_next   = VALUE_WIDTH'(req.value);
                    state_next = S_EXEC;
                end
            end

            // dispatch on the captured request
            S_EXEC:
            begin
                idx_next        = '0;
                rd_done_next    = 1'b0;
                pend_next       = 1'b0;
                pend_first_next = 1'b1;
                res_next        = '0;
                case (op_reg)
                    OP_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            fin             = 1'b1;
                            fin_resp.status = ST_FULL;
                            state_next      = S_IDLE;
                        end
                        else if (is_empty)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = '0;
                            count_next = count_reg + CW'(1);
                            fin        = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = last_idx;
                            state_next = S_SHUP;
                        end
                    end
                    OP_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            fin_resp.status = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                    OP_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            fin             = 1'b1;
                            fin_resp.status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SHDN;
                        end
                    end
                    OP_POP_BACK, OP_HEAD, OP_TAIL:
                    begin
                        if (is_empty)
                        begin
                            fin             = 1'b1;
                            fin_resp.status = ST_EMPTY;
                            state_next      = S_IDLE;
                        end
                        else
                        begin
                            mem_raddr  = (op_reg == OP_HEAD) ? '0 : last_idx;
                            state_next = S_RDWT;
                        end
                    end
                    OP_DELETE, OP_CONTAINS:
                    begin
                        if (is_empty)
                        begin
                            fin = 1'b1;
                            if (op_reg == OP_DELETE)
                            begin
                                fin_resp.status = ST_NOTFOUND;
                            end
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end

            // move entries up one place, top first, then put key at the head
            S_SHUP:
            begin
                if (!rd_done_reg)
                begin
                    mem_raddr      = idx_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    if (idx_reg == '0)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg + AW'(1);
                    mem_wdata = mem_rdata;
                end
                else if (rd_done_reg)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = key_reg;
                    count_next = count_reg + CW'(1);
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // drop the first entry read and move the rest down one place
            S_SHDN:
            begin
                if (!rd_done_reg)
                begin
                    mem_raddr      = idx_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    if (idx_reg == last_idx)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    pend_first_next = 1'b0;
                    if (pend_first_reg)
                    begin
                        if (op_reg == OP_POP_FRONT)
                        begin
                            res_next = mem_rdata;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pend_addr_reg - AW'(1);
                        mem_wdata = mem_rdata;
                    end
                end
                else if (rd_done_reg)
                begin
                    count_next = cnt_m1;
                    fin        = 1'b1;
                    if (op_reg == OP_POP_FRONT)
                    begin
                        fin_resp.result_value = 32'(res_reg);
                    end
                    fin_resp.found = (op_reg == OP_DELETE);
                    state_next     = S_IDLE;
                end
            end

            // search from the head for the first entry equal to the key
            S_SCAN:
            begin
                if (!rd_done_reg)
                begin
                    mem_raddr      = idx_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg;
                    if (idx_reg == last_idx)
                    begin
                        rd_done_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && key_hit)
                begin
                    if (op_reg == OP_DELETE)
                    begin
                        idx_next        = pend_addr_reg;
                        rd_done_next    = 1'b0;
                        pend_next       = 1'b0;
                        pend_first_next = 1'b1;
                        state_next      = S_SHDN;
                    end
                    else
                    begin
                        fin            = 1'b1;
                        fin_resp.found = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (rd_done_reg && !pend_reg)
                begin
                    fin = 1'b1;
                    if (op_reg == OP_DELETE)
                    begin
                        fin_resp.status = ST_NOTFOUND;
                    end
                    state_next = S_IDLE;
                end
            end

            // single read for pop back and peeks
            S_RDWT:
            begin
                fin_resp.result_value = 32'(mem_rdata);
                if (op_reg == OP_POP_BACK)
                begin
                    count_next = cnt_m1;
                end
                fin        = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        fin_resp.entry_count = 5'(count_next);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            rd_done_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            pend_first_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_done_reg    <= rd_done_next;
            pend_reg       <= pend_next;
            pend_first_reg <= pend_first_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        idx_reg       <= idx_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    // checks
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> (state_reg == S_IDLE))
        else $error("sequencer not idle after finishing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fin && fin_resp.status == ST_EMPTY) |-> (fin_resp.result_value == '0))
        else $error("empty answer carries a value");

endmodule

// ===== hw/rtl/bounded_list_deque.sv =====
// ----------------------------------------------------------------------------
// bounded_list_deque
// Bounded ordered list held densely from position 0, served as a deque with
// delete-by-value and membership test.
//
//   channel   | signals          | handshake
//   ----------+------------------+-----------------------------------------
//   request   | start, req       | beat taken when start is high, busy low
//   response  | done, resp       | one-cycle strobe, always taken
//
// Push back finishes in the dispatch state; peeks and pop back pass through
// a read wait state; push front, pop front, contains and delete walk the list.
// Walks are bounded by the single memory read port, walked one entry a cycle
// by the sequencer.
// busy is high from the cycle after accept until the result strobe.
// Reset empties the list; there is no clearing pass over the memory.
// The receiver cannot stall: each result is strobed on done for one cycle only.
// ----------------------------------------------------------------------------
module bounded_list_deque #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bld_pkg::bld_req_t    req,
    output logic                 busy,
    output logic                 done,
    output bld_pkg::bld_resp_t   resp
);
    import bld_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;
    logic                   fin;
    bld_resp_t              fin_resp;

    logic                   done_reg;
    bld_resp_t              resp_reg;

    // entry memory
    bld_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // sequencer
    bld_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .fin       (fin),
        .fin_resp  (fin_resp)
    );

    // response strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin;
        end
    end

    // response beat
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            resp_reg <= fin_resp;
        end
    end

    assign done = done_reg;
    assign resp = resp_reg;

endmodule
